FILE: rtl/core/page_table_frame_allocator_core_assert.svh
// Assertion macros for the frame allocator core.
// Used by the allocator core module; no other dependencies.
`ifndef PAGE_TABLE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_TABLE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PTFA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define PTFA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/core/ptfa_pkg.sv
// Frame allocator core package: sizes, command, status and CSR codes.
// No dependencies.
`default_nettype none
package ptfa_pkg;
   localparam int NumFrames = 64;
   localparam int MaxProcs  = 16;
   localparam int FrameW    = $clog2(NumFrames);
   localparam int CountW    = $clog2(NumFrames + 1);
   localparam int PidW      = 4;
   localparam int ProcW     = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
   localparam int PtAddrW   = ProcW + FrameW;

   localparam logic [1:0] CMD_RESIZE    = 2'd0;
   localparam logic [1:0] CMD_TRANSLATE = 2'd1;
   localparam logic [1:0] CMD_RELEASE   = 2'd2;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFRAME = 2'd1;
   localparam logic [1:0] ST_NOPROC  = 2'd2;
   localparam logic [1:0] ST_BEYOND  = 2'd3;

   localparam logic CSR_PAGE_BYTES = 1'b0;
   localparam logic CSR_FRAMES     = 1'b1;

   typedef struct packed {
      logic                 we;
      logic [PtAddrW-1:0]   waddr;
      logic [FrameW-1:0]    wdata;
      logic                 re;
      logic [PtAddrW-1:0]   raddr;
   } pt_req_type;
endpackage
`default_nettype wire

FILE: rtl/core/page_table_frame_allocator_core.sv
// Frame allocator core: per-process page tables over a frame bitmap.
// Resize divides the size by the page size; a grow then counts free frames at
// one frame a cycle and allocates one page a cycle, while a shrink reads then
// frees each dropped page in turn; translate reads the page table and returns
// the frame; release reads then frees each page. One transaction is in flight
// at a time; the result register frees the input as soon as the result is
// taken or parked. Page-frame memory is not cleared at reset.
// Depends on ptfa_pkg, ptfa_divider, ptfa_page_ram and the assertion header.
`default_nettype none
`include "page_table_frame_allocator_core_assert.svh"
module page_table_frame_allocator_core import ptfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [3:0]  req_pid,
   input  wire logic [31:0] req_size_bytes,
   input  wire logic [5:0]  req_page_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [5:0]       rsp_frame,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DIV   = 8'b0000_0010,
      S_COUNT = 8'b0000_0100,
      S_GROW  = 8'b0000_1000,
      S_RDPG  = 8'b0001_0000,
      S_DROP  = 8'b0010_0000,
      S_TRANS = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [16:0] page_bytes_ff;
   logic [6:0]  frames_ff;
   logic [NumFrames-1:0] used_ff, used_in;
   logic [MaxProcs-1:0]  pvalid_ff, pvalid_in;
   logic [CountW-1:0]    pcount_ff [MaxProcs];
   logic [CountW-1:0]    count_wr;
   logic                 count_we;
   logic [1:0]  cmd_ff;
   logic [ProcW-1:0] pid_ff;
   logic [CountW-1:0] want_ff, want_in, idx_ff, idx_in, end_ff, end_in;
   logic [CountW-1:0] free_ff, free_in;
   logic [FrameW-1:0] scan_ff, scan_in;
   logic [1:0] st_ff, st_in;
   logic [5:0] fr_ff, fr_in;
   logic       rv_ff, rv_in;
   logic [1:0] ost_ff;
   logic [5:0] ofr_ff;
   logic       div_start, div_done;
   logic [32:0] quot;
   logic [FrameW-1:0] rdata;
   pt_req_type ram_req;
   logic [FrameW:0] lim;
   logic [FrameW-1:0] low_free;
   logic        found;
   logic        acc;
   logic [CountW-1:0] old_cnt;

   assign lim = (frames_ff > 7'(NumFrames)) ? (FrameW+1)'(NumFrames)
                                            : (FrameW+1)'(frames_ff);
   assign old_cnt = pvalid_ff[pid_ff] ? pcount_ff[pid_ff] : '0;
   assign req_ready = (state_ff == S_IDLE);
   assign acc = req_valid && req_ready;
   assign csr_ready = 1'b1;

   ptfa_divider u_div (
      .clock, .reset, .start(div_start), .dividend(req_size_bytes),
      .divisor(page_bytes_ff), .done(div_done), .quotient(quot)
   );
   ptfa_page_ram u_ram (.clock, .req(ram_req), .rdata);

   always_comb begin
      found = 1'b0; low_free = '0;
      for (int i = NumFrames - 1; i >= 0; i--) begin
         if (!used_ff[i] && ((FrameW+1)'(i) < lim)) begin
            found = 1'b1; low_free = FrameW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff; used_in = used_ff; pvalid_in = pvalid_ff;
      count_we = 1'b0; count_wr = '0;
      want_in = want_ff; idx_in = idx_ff; end_in = end_ff;
      free_in = free_ff; scan_in = scan_ff;
      st_in = st_ff; fr_in = fr_ff; rv_in = rv_ff;
      div_start = 1'b0; ram_req = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               st_in = ST_OK; fr_in = '0;
               if (req_cmd == CMD_UNUSED) state_in = S_DONE;
               else if (32'(req_pid) >= MaxProcs) begin
                  st_in = ST_NOPROC; state_in = S_DONE;
               end else if (req_cmd == CMD_RESIZE) state_in = S_DIV;
               else if (!pvalid_ff[ProcW'(req_pid)]) begin
                  st_in = ST_NOPROC; state_in = S_DONE;
               end else if (req_cmd == CMD_TRANSLATE) begin
                  if (CountW'(req_page_index) >= pcount_ff[ProcW'(req_pid)]) begin
                     st_in = ST_BEYOND; state_in = S_DONE;
                  end else begin
                     ram_req.re = 1'b1;
                     ram_req.raddr = {ProcW'(req_pid), FrameW'(req_page_index)};
                     state_in = S_TRANS;
                  end
               end else begin
                  idx_in = '0; end_in = pcount_ff[ProcW'(req_pid)];
                  want_in = '0; state_in = S_RDPG;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (quot > 33'(old_cnt)) begin
                  if (quot > 33'(NumFrames)) begin
                     st_in = ST_NOFRAME; state_in = S_DONE;
                  end else begin
                     want_in = CountW'(quot); free_in = '0; scan_in = '0;
                     state_in = S_COUNT;
                  end
               end else begin
                  want_in = CountW'(quot); idx_in = CountW'(quot);
                  end_in = old_cnt; state_in = S_RDPG;
               end
            end
         end
         S_COUNT: begin
            if (!used_ff[scan_ff] && ((FrameW+1)'(scan_ff) < lim))
               free_in = free_ff + CountW'(1);
            scan_in = scan_ff + FrameW'(1);
            if (scan_ff == FrameW'(NumFrames - 1)) begin
               if (want_ff - old_cnt > free_in) begin
                  st_in = ST_NOFRAME; state_in = S_DONE;
               end else begin
                  idx_in = old_cnt; state_in = S_GROW;
               end
            end
         end
         S_GROW: begin
            if (idx_ff == want_ff) begin
               pvalid_in[pid_ff] = 1'b1; count_we = 1'b1; count_wr = want_ff;
               state_in = S_DONE;
            end else begin
               used_in[low_free] = 1'b1;
               ram_req.we = 1'b1;
               ram_req.waddr = {pid_ff, idx_ff[FrameW-1:0]};
               ram_req.wdata = low_free;
               idx_in = idx_ff + CountW'(1);
            end
         end
         S_RDPG: begin
            if (idx_ff == end_ff) begin
               count_we = 1'b1; count_wr = want_ff;
               pvalid_in[pid_ff] = (cmd_ff == CMD_RESIZE);
               state_in = S_DONE;
            end else begin
               ram_req.re = 1'b1;
               ram_req.raddr = {pid_ff, idx_ff[FrameW-1:0]};
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            used_in[rdata] = 1'b0;
            idx_in = idx_ff + CountW'(1);
            state_in = S_RDPG;
         end
         S_TRANS: begin
            fr_in = rdata; state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_in) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE && acc && req_cmd == CMD_RESIZE &&
          32'(req_pid) < MaxProcs) div_start = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         cmd_ff <= req_cmd; pid_ff <= ProcW'(req_pid);
      end
      want_ff <= want_in; idx_ff <= idx_in; end_ff <= end_in;
      free_ff <= free_in; scan_ff <= scan_in; st_ff <= st_in; fr_ff <= fr_in;
      if (state_ff == S_DONE && state_in == S_IDLE) begin
         ost_ff <= st_ff; ofr_ff <= fr_ff;
      end
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0;
         used_ff <= '0; pvalid_ff <= '0;
         page_bytes_ff <= 17'd32; frames_ff <= 7'd64;
         for (int i = 0; i < MaxProcs; i++) pcount_ff[i] <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in;
         used_ff <= used_in; pvalid_ff <= pvalid_in;
         if (count_we) pcount_ff[pid_ff] <= count_wr;
         if (csr_valid && csr_index == CSR_PAGE_BYTES) page_bytes_ff <= csr_data[16:0];
         if (csr_valid && csr_index == CSR_FRAMES) frames_ff <= csr_data[6:0];
      end
   end

   assign rsp_valid  = rv_ff;
   assign rsp_status = ost_ff;
   assign rsp_frame  = ofr_ff;

   `PTFA_ASSERT_IMP(a_grow_has_frame, clock, reset,
      state_ff == S_GROW && idx_ff != want_ff, found)
   `PTFA_ASSERT_NXT(a_accept_leaves_idle, clock, reset, acc, state_ff != S_IDLE)
   `PTFA_ASSERT_IMP(a_frame_only_ok, clock, reset,
      rsp_valid && rsp_status != ST_OK, rsp_frame == '0)
endmodule
`default_nettype wire

FILE: rtl/core/ptfa_divider.sv
// Restoring divider: ceil(size / page_bytes), one quotient bit a cycle.
// Depends on ptfa_pkg.
`default_nettype none
module ptfa_divider import ptfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [16:0] divisor,
   output logic             done,
   output logic [32:0]      quotient
);
   logic [32:0] num_ff, num_in;
   logic [16:0] den_ff, den_in;
   logic [17:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [17:0] trial;
   logic [17:0] sub;

   always_comb begin
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[16:0], num_ff[32]};
      sub = trial - {1'b0, den_ff};
      if (start) begin
         den_in  = (divisor == 17'd0) ? 17'd1 : divisor;
         num_in  = {1'b0, dividend} + {16'd0, den_in} - 33'd1;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[31:0], 1'b0};
         if (!sub[17]) begin
            rem_in = sub;
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/core/ptfa_page_ram.sv
// Page-frame memory: one write port, one registered read port.
// Depends on ptfa_pkg.
`default_nettype none
module ptfa_page_ram import ptfa_pkg::*; (
   input  wire logic              clock,
   input  wire pt_req_type        req,
   output logic [FrameW-1:0]      rdata
);
   logic [FrameW-1:0] mem [MaxProcs*NumFrames];
   logic [FrameW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (req.we) mem[req.waddr] <= req.wdata;
      if (req.re) rd_ff <= mem[req.raddr];
   end
   assign rdata = rd_ff;
endmodule
`default_nettype wire
